### rtl/detector_rolloff_augment_unit_macros.svh
// Assertion macros for the detector roll-off augment unit.
// Each macro samples on clk_i and stands down while rst_ni is low.
`ifndef DETECTOR_ROLLOFF_AUGMENT_UNIT_MACROS_SVH
`define DETECTOR_ROLLOFF_AUGMENT_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle brings another in the next.
`define DRA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### rtl/dra_pkg.sv
// Shared types, constants and detector tables for the roll-off augment unit.
// No dependencies.
package dra_pkg;

  typedef enum logic [1:0] {
    CFG_KIND     = 2'd0,
    CFG_STRENGTH = 2'd1,
    CFG_NOISE    = 2'd2,
    CFG_BASELINE = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] strength;
    logic [15:0] noise_gain;
    logic        baseline_en;
  } cfg_t;

  localparam logic [2:0]  NUM_KINDS    = 3'd5;
  localparam logic [16:0] Q16_ONE      = 17'd65536;
  localparam logic [16:0] SENS_CLIP_LO = 17'd6554;
  // ceil(2^34 / 125): exact quotient for numerators below 2^27
  localparam logic [27:0] RECIP125     = 28'd137438954;
  // ceil(2^32 / 100): exact quotient for numerators below 2^25
  localparam logic [25:0] RECIP100     = 26'd42949673;
  // log2(e) in Q16
  localparam logic [16:0] LOG2E_Q16    = 17'd94548;

  function automatic logic [15:0] band_lo_q4(input logic [2:0] k);
    case (k)
      3'd0:    band_lo_q4 = 16'd16000;
      3'd1:    band_lo_q4 = 16'd17600;
      3'd2:    band_lo_q4 = 16'd16000;
      3'd3:    band_lo_q4 = 16'd6400;
      3'd4:    band_lo_q4 = 16'd14400;
      default: band_lo_q4 = 16'd0;
    endcase
  endfunction

  function automatic logic [15:0] band_hi_q4(input logic [2:0] k);
    case (k)
      3'd0:    band_hi_q4 = 16'd25600;
      3'd1:    band_hi_q4 = 16'd35200;
      3'd2:    band_hi_q4 = 16'd44800;
      3'd3:    band_hi_q4 = 16'd14400;
      3'd4:    band_hi_q4 = 16'd27200;
      default: band_hi_q4 = 16'hFFFF;
    endcase
  endfunction

  function automatic logic [3:0] rate_milli(input logic [2:0] k);
    case (k)
      3'd0:    rate_milli = 4'd8;
      3'd1:    rate_milli = 4'd5;
      3'd2:    rate_milli = 4'd4;
      3'd3:    rate_milli = 4'd15;
      3'd4:    rate_milli = 4'd6;
      default: rate_milli = 4'd0;
    endcase
  endfunction

  function automatic logic [15:0] floor_q16(input logic [2:0] k);
    case (k)
      3'd0:    floor_q16 = 16'd19661;
      3'd1:    floor_q16 = 16'd13107;
      3'd2:    floor_q16 = 16'd16384;
      3'd3:    floor_q16 = 16'd6554;
      3'd4:    floor_q16 = 16'd22938;
      default: floor_q16 = 16'd0;
    endcase
  endfunction

  // 2^(-i/16) in Q16
  function automatic logic [16:0] pow2_neg16(input logic [3:0] i);
    case (i)
      4'd0:    pow2_neg16 = 17'd65536;
      4'd1:    pow2_neg16 = 17'd62757;
      4'd2:    pow2_neg16 = 17'd60097;
      4'd3:    pow2_neg16 = 17'd57549;
      4'd4:    pow2_neg16 = 17'd55109;
      4'd5:    pow2_neg16 = 17'd52773;
      4'd6:    pow2_neg16 = 17'd50535;
      4'd7:    pow2_neg16 = 17'd48393;
      4'd8:    pow2_neg16 = 17'd46341;
      4'd9:    pow2_neg16 = 17'd44376;
      4'd10:   pow2_neg16 = 17'd42495;
      4'd11:   pow2_neg16 = 17'd40693;
      4'd12:   pow2_neg16 = 17'd38968;
      4'd13:   pow2_neg16 = 17'd37316;
      4'd14:   pow2_neg16 = 17'd35734;
      default: pow2_neg16 = 17'd34219;
    endcase
  endfunction

endpackage

### rtl/dra_sens.sv
// Sensitivity pipeline: band distance, exponent scaling, exp(-x) and floor blend.
// Depends on dra_pkg.
module dra_sens import dra_pkg::*; #(
  parameter int PAY_W = 49
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [15:0]      wl_i,
  input  logic [PAY_W-1:0] pay_i,
  input  cfg_t             cfg_i,
  output logic             valid_o,
  output logic [16:0]      sens_o,
  output logic             kind_ok_o,
  output logic [PAY_W-1:0] pay_o
);

  localparam int NS = 10;

  typedef struct packed {
    logic             kind_ok;
    logic             outside;
    logic [15:0]      fl;
    logic [PAY_W-1:0] pay;
  } side_t;

  logic [NS-1:0] vld_q;
  side_t         side_q [NS];
  side_t         side_d;

  logic [15:0] lo, hi, dist_d;
  logic [19:0] rs_d;

  logic [15:0] dist_q;
  logic [19:0] rs_q;
  logic [36:0] num_q, num_d;
  logic        big3_q, big4_q;
  logic [54:0] qp_q;
  logic [37:0] y_q;
  logic [5:0]  n5;
  logic [27:0] tp;
  logic [11:0] t5_q, t6_q;
  logic [3:0]  idx5_q, idx6_q, idx7_q;
  logic [4:0]  nsh5_q, nsh6_q, nsh7_q, nsh8_q;
  logic        zero5_q, zero6_q, zero7_q, zero8_q;
  logic [24:0] t2p;
  logic [8:0]  t2_q;
  logic [21:0] t3p;
  logic [5:0]  t3;
  logic [11:0] t3x43;
  logic [16:0] poly_q;
  logic [33:0] mp;
  logic [16:0] m_q, e9;
  logic [33:0] sp_q, spr;
  logic [16:0] sens_q;

  always_comb begin
    lo             = band_lo_q4(cfg_i.kind);
    hi             = band_hi_q4(cfg_i.kind);
    side_d.kind_ok = (cfg_i.kind < NUM_KINDS);
    side_d.fl      = floor_q16(cfg_i.kind);
    side_d.pay     = pay_i;
    side_d.outside = 1'b0;
    dist_d         = '0;
    if (wl_i < lo) begin
      dist_d         = lo - wl_i;
      side_d.outside = side_d.kind_ok;
    end else if (wl_i > hi) begin
      dist_d         = wl_i - hi;
      side_d.outside = side_d.kind_ok;
    end
    rs_d = {16'd0, rate_milli(cfg_i.kind)} * {4'd0, cfg_i.strength};
  end

  // y_q holds x * log2(e) before the 16-bit shift: integer part in [37:32],
  // table index in [31:28], series remainder in [27:16]
  assign num_d = {36'(rs_q) * 36'(dist_q), 1'b0} + 37'd62;
  assign n5    = y_q[37:32];
  assign tp    = 28'(y_q[27:16]) * 28'(16'd45426) + 28'd32768;
  assign t2p   = 25'(t5_q) * 25'(t5_q) + 25'd32768;
  assign t3p   = 22'(t2_q) * 22'(t6_q) + 22'd32768;
  assign t3    = t3p[21:16];
  // t3 / 6 as t3 * 43 / 256, exact for six-bit values
  assign t3x43 = 12'(t3) * 12'd43;
  assign mp    = 34'(pow2_neg16(idx7_q)) * 34'(poly_q) + 34'd32768;
  assign e9    = zero8_q ? 17'd0 : (m_q >> nsh8_q);
  assign spr   = sp_q + 34'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_d;
      for (int i = 1; i < NS; i++) begin
        side_q[i] <= side_q[i-1];
      end
      // distance and rate times strength
      dist_q  <= dist_d;
      rs_q    <= rs_d;
      // exponent numerator
      num_q   <= num_d;
      // x = round(num / 125) by reciprocal
      big3_q  <= |num_q[36:27];
      qp_q    <= 55'(num_q[26:0]) * 55'(RECIP125);
      // y = x * log2(e)
      big4_q  <= big3_q;
      y_q     <= 38'(qp_q[54:34]) * 38'(LOG2E_Q16);
      // split y, first Taylor term
      zero5_q <= big4_q || (n5 > 6'd16);
      nsh5_q  <= n5[4:0];
      idx5_q  <= y_q[31:28];
      t5_q    <= tp[27:16];
      // t squared
      t6_q    <= t5_q;
      t2_q    <= t2p[24:16];
      idx6_q  <= idx5_q;
      nsh6_q  <= nsh5_q;
      zero6_q <= zero5_q;
      // cubic term and polynomial
      poly_q  <= Q16_ONE - 17'(t6_q) + 17'(t2_q >> 1) - 17'(t3x43[11:8]);
      idx7_q  <= idx6_q;
      nsh7_q  <= nsh6_q;
      zero7_q <= zero6_q;
      // table times polynomial
      m_q     <= mp[32:16];
      nsh8_q  <= nsh7_q;
      zero8_q <= zero7_q;
      // shift by the integer part, scale the span above the floor
      sp_q    <= 34'(Q16_ONE - {1'b0, side_q[7].fl}) * 34'(e9);
      // add the floor
      sens_q  <= side_q[8].outside ? ({1'b0, side_q[8].fl} + spr[32:16]) : Q16_ONE;
    end
  end

  assign valid_o   = vld_q[NS-1];
  assign sens_o    = sens_q;
  assign kind_ok_o = side_q[NS-1].kind_ok;
  assign pay_o     = side_q[NS-1].pay;

endmodule

### rtl/dra_div.sv
// Pipelined reciprocal: inv = round(2^32 / max(sens, floor clip)) - 2^16,
// one quotient bit per stage. Depends on dra_pkg.
module dra_div import dra_pkg::*; #(
  parameter int SIDE_W = 67
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [16:0]       sens_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [19:0]       inv_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int QB = 20;

  logic [QB-1:0]     vld_q;
  logic [16:0]       rem_q  [QB];
  logic [16:0]       sc_q   [QB];
  logic [QB-1:0]     quo_q  [QB];
  logic [SIDE_W-1:0] side_q [QB];
  logic [16:0]       sc_in;

  assign sc_in = (sens_i < SENS_CLIP_LO) ? SENS_CLIP_LO : sens_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QB-2:0], valid_i};
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_step
    localparam int B = QB - 1 - i;
    logic [16:0]   rem_p, sc_p, rem_d;
    logic [QB-1:0] quo_p;
    logic [15:0]   half;
    logic          dbit, ge;
    logic [17:0]   trial;

    if (i == 0) begin : g_first
      // top dividend bits of 2^32 + sc/2 are exactly 4096
      assign rem_p = 17'd4096;
      assign sc_p  = sc_in;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[i-1];
      assign sc_p  = sc_q[i-1];
      assign quo_p = quo_q[i-1];
    end

    assign half = sc_p[16:1];
    if (B < 16) begin : g_low
      assign dbit = half[B];
    end else begin : g_high
      assign dbit = 1'b0;
    end

    assign trial = {rem_p, dbit};
    assign ge    = (trial >= {1'b0, sc_p});
    assign rem_d = ge ? 17'(trial - {1'b0, sc_p}) : trial[16:0];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        sc_q[i]  <= sc_p;
        quo_q[i] <= quo_p | (QB'(ge) << B);
        side_q[i] <= (i == 0) ? side_i : side_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign inv_o   = quo_q[QB-1] - 20'd65536;
  assign side_o  = side_q[QB-1];

endmodule

### rtl/dra_mix.sv
// Output pipeline: noise term, baseline term, sum and saturation.
// Depends on dra_pkg and the unit's assertion macros.
`include "detector_rolloff_augment_unit_macros.svh"
module dra_mix import dra_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int NOISE_WIDTH  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [19:0]             inv_i,
  input  logic [16:0]             sens_i,
  input  logic                    kind_ok_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [NOISE_WIDTH-1:0]  noise_i,
  input  logic                    row_end_i,
  input  cfg_t                    cfg_i,
  output logic                    valid_o,
  output logic [SAMPLE_WIDTH-1:0] out_value_o,
  output logic                    saturated_o,
  output logic                    row_end_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int NW    = NOISE_WIDTH;
  localparam int ACC_W = SW + NW + 4;
  localparam int NS    = 5;
  localparam logic [ACC_W-1:0] SMAX_A = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic [ACC_W-1:0] SMIN_A = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

  typedef struct packed {
    logic          kind_ok;
    logic          neg;
    logic          row_end;
    logic [SW-1:0] sample;
  } side_t;

  logic [NS-1:0] vld_q;
  side_t         side_q [NS];
  side_t         side_d;

  logic [NW-1:0]    mag;
  logic [NW+19:0]   a_q;
  logic [32:0]      bln_q;
  logic [NW+35:0]   pf_q;
  logic [50:0]      bq_q;
  logic [NW+36:0]   pr;
  logic [NW+16:0]   p_q;
  logic [18:0]      bl_q;
  logic [ACC_W-1:0] ps, acc_d, acc_q;
  logic [SW-1:0]    out_q;
  logic             sat_q;

  assign side_d = '{kind_ok: kind_ok_i, neg: noise_i[NW-1], row_end: row_end_i,
                    sample: sample_i};
  assign mag    = noise_i[NW-1] ? (~noise_i + NW'(1)) : noise_i;
  assign pr     = {1'b0, pf_q} + (NW+37)'(20'h80000);
  assign ps     = side_q[2].neg ? (ACC_W'(0) - ACC_W'(p_q)) : ACC_W'(p_q);
  assign acc_d  = {{(ACC_W-SW){side_q[2].sample[SW-1]}}, side_q[2].sample} + ps
                  + ACC_W'(bl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_d;
      for (int i = 1; i < NS; i++) begin
        side_q[i] <= side_q[i-1];
      end
      a_q   <= (NW+20)'(mag) * (NW+20)'(inv_i);
      bln_q <= 33'(Q16_ONE - sens_i) * 33'(cfg_i.strength) + 33'd12800;
      pf_q  <= (NW+36)'(a_q) * (NW+36)'(cfg_i.noise_gain);
      // baseline: (v + 12800) / 25600 as ((v + 12800) >> 8) / 100
      bq_q  <= 51'(bln_q[32:8]) * 51'(RECIP100);
      p_q   <= pr[NW+36:20];
      bl_q  <= cfg_i.baseline_en ? bq_q[50:32] : 19'd0;
      acc_q <= acc_d;
      // clip to the sample range; unknown kinds pass the sample through
      if (!side_q[3].kind_ok) begin
        out_q <= side_q[3].sample;
        sat_q <= 1'b0;
      end else if ($signed(acc_q) > $signed(SMAX_A)) begin
        out_q <= SMAX_A[SW-1:0];
        sat_q <= 1'b1;
      end else if ($signed(acc_q) < $signed(SMIN_A)) begin
        out_q <= SMIN_A[SW-1:0];
        sat_q <= 1'b1;
      end else begin
        out_q <= acc_q[SW-1:0];
        sat_q <= 1'b0;
      end
    end
  end

  assign valid_o     = vld_q[NS-1];
  assign out_value_o = out_q;
  assign saturated_o = sat_q;
  assign row_end_o   = side_q[NS-1].row_end;

  `DRA_ASSERT(a_mix_hold, !en_i |=> $stable(vld_q), "mix stages moved while stalled")
  `DRA_ASSERT(a_mix_unk, valid_o && !side_q[NS-1].kind_ok |-> !saturated_o, "pass-through clipped")
  `DRA_ASSERT(a_mix_pass, valid_o && !side_q[NS-1].kind_ok |-> out_q == side_q[NS-1].sample, "pass-through changed")

endmodule

### rtl/detector_rolloff_augment_unit.sv
// Detector roll-off augmentation: per-sample sensitivity weighting with noise and baseline.
// Top level; instantiates dra_sens, dra_div, dra_mix; uses dra_pkg and the assertion macros.
//
// Usage:
//   Input items arrive on the s_axis group, one spectral sample each, with its
//   wavelength and noise draw in tdata and the end-of-row marker on tlast. Each
//   item yields exactly one result on the m_axis group: the augmented sample in
//   tdata, the clip flag in tuser and the row marker copied to tlast.
//   Configuration is written through cfg_we_i / cfg_addr_i / cfg_data_i, one
//   register per write, while no item is in flight.
// Throughput and pipeline:
//   One item per cycle, sustained while m_axis is not stalled. An accepted item
//   passes through 10 stages that form the sensitivity (band distance, exp(-x) by a
//   table and a cubic series), 20 stages that form the reciprocal one quotient bit
//   at a time, 5 stages that build the noise and baseline terms and saturate, and
//   one output register that drives m_axis.
// Reset:
//   rst_ni clears all valid bits and the output stage; registers return to
//   kind 0, strength 1.0, noise off, baseline off.
// Stalls:
//   When m_axis_tready drops, the next result from the pipeline parks in a
//   one-item skid register; from then on the whole pipeline holds and
//   s_axis_tready stays low until the skid empties. Nothing is lost or repeated.
`include "detector_rolloff_augment_unit_macros.svh"
module detector_rolloff_augment_unit import dra_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int NOISE_WIDTH  = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // s_axis_tdata: sample_value, wavelength_nm (Q4), noise_sample (lowest bit up), zero fill
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  input  logic [((SAMPLE_WIDTH+16+NOISE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                        s_axis_tlast,
  // m_axis_tdata: out_value, zero fill; m_axis_tuser: saturated
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]           m_axis_tdata,
  output logic                                        m_axis_tuser,
  output logic                                        m_axis_tlast,
  input  logic                                        cfg_we_i,
  input  logic [1:0]                                  cfg_addr_i,
  input  logic [15:0]                                 cfg_data_i
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int NW     = NOISE_WIDTH;
  localparam int ODW    = ((SW + 7) / 8) * 8;
  localparam int PAY_W  = SW + NW + 1;
  localparam int SIDE_W = 17 + 1 + PAY_W;
  localparam int ITEM_W = SW + 2;
  localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  cfg_t cfg_q;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind        <= 3'd0;
      cfg_q.strength    <= 16'd256;
      cfg_q.noise_gain  <= 16'd0;
      cfg_q.baseline_en <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_KIND:     cfg_q.kind        <= cfg_data_i[2:0];
        CFG_STRENGTH: cfg_q.strength    <= cfg_data_i;
        CFG_NOISE:    cfg_q.noise_gain  <= cfg_data_i;
        CFG_BASELINE: cfg_q.baseline_en <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  logic              en;
  logic [SW-1:0]     in_sample;
  logic [15:0]       in_wl;
  logic [NW-1:0]     in_noise;
  logic [PAY_W-1:0]  pay_in, pay_s, pay_d;
  logic              sens_vld, div_vld, mix_vld;
  logic [16:0]       sens, sens_d;
  logic              kind_ok, kind_ok_d;
  logic [SIDE_W-1:0] side_s, side_d;
  logic [19:0]       inv;
  logic [SW-1:0]     mix_value;
  logic              mix_sat, mix_last;

  assign in_sample = s_axis_tdata[SW-1:0];
  assign in_wl     = s_axis_tdata[SW+15:SW];
  assign in_noise  = s_axis_tdata[SW+16+NW-1:SW+16];
  assign pay_in    = {in_sample, in_noise, s_axis_tlast};

  dra_sens #(.PAY_W(PAY_W)) u_sens (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .wl_i      (in_wl),
    .pay_i     (pay_in),
    .cfg_i     (cfg_q),
    .valid_o   (sens_vld),
    .sens_o    (sens),
    .kind_ok_o (kind_ok),
    .pay_o     (pay_s)
  );

  assign side_s = {sens, kind_ok, pay_s};

  dra_div #(.SIDE_W(SIDE_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sens_vld),
    .sens_i  (sens),
    .side_i  (side_s),
    .valid_o (div_vld),
    .inv_o   (inv),
    .side_o  (side_d)
  );

  assign {sens_d, kind_ok_d, pay_d} = side_d;

  dra_mix #(.SAMPLE_WIDTH(SW), .NOISE_WIDTH(NW)) u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (div_vld),
    .inv_i       (inv),
    .sens_i      (sens_d),
    .kind_ok_i   (kind_ok_d),
    .sample_i    (pay_d[PAY_W-1:NW+1]),
    .noise_i     (pay_d[NW:1]),
    .row_end_i   (pay_d[0]),
    .cfg_i       (cfg_q),
    .valid_o     (mix_vld),
    .out_value_o (mix_value),
    .saturated_o (mix_sat),
    .row_end_o   (mix_last)
  );

  // output register plus one-item skid; the pipeline advances only while the skid is empty
  logic              out_valid_q, skid_valid_q;
  logic [ITEM_W-1:0] out_q, skid_q, mix_item;

  assign mix_item = {mix_value, mix_sat, mix_last};
  assign en       = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || mix_vld;
      skid_valid_q <= 1'b0;
    end else if (en && mix_vld) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : mix_item;
    end else if (en && mix_vld) begin
      skid_q <= mix_item;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'(out_q[ITEM_W-1:2]);
  assign m_axis_tuser  = out_q[1];
  assign m_axis_tlast  = out_q[0];

  `DRA_ASSERT(a_skid_only_when_full, skid_valid_q |-> out_valid_q, "skid holds item with empty output")
  `DRA_ASSERT(a_ready_drop, $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready), "ready fell without stall")
  `DRA_ASSERT_NEXT(a_skid_hold, skid_valid_q && !m_axis_tready, skid_valid_q, "skid item lost under stall")
  `DRA_ASSERT(a_sat_value, m_axis_tvalid && m_axis_tuser |-> out_q[ITEM_W-1:2] == SMAX || out_q[ITEM_W-1:2] == SMIN, "clip flag without clipped value")

endmodule
